FILE: hw/rtl/kmpq_pkg.sv
// Shared types and constants for the keyed minimum priority queue.
`default_nettype none
package kmpq_pkg;

	localparam int DEPTH    = 64;
	localparam int KEY_BITS = 16;
	localparam int VAL_W    = 32;
	localparam int IN_KEY_W = 16;
	localparam int FILL_W   = 7;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_UPD = 2'd1;
	localparam logic [1:0] MODE_DEQ = 2'd2;

	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;
	localparam logic [1:0] STAT_ABSENT = 2'd3;

	typedef logic [KEY_BITS-1:0]     key_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IN_KEY_W-1:0]     in_key;
		logic signed [VAL_W-1:0] in_value;
	} in_t;

	typedef struct packed {
		logic [IN_KEY_W-1:0]     out_key;
		logic signed [VAL_W-1:0] out_value;
		logic                    out_valid;
		logic [1:0]              status;
		logic                    queue_empty;
		logic [FILL_W-1:0]       fill_level;
	} out_t;

	typedef struct packed {
		logic valid;
		key_t key;
		val_t value;
	} ent_t;

	typedef struct packed {
		ent_t ent;
		logic lt;
		logic le;
	} nb_t;

	typedef struct packed {
		logic load;
		key_t key;
		val_t value;
	} cmp_t;

	typedef struct packed {
		logic apply;
		logic ins;
		logic sel_lt;
		logic rm_here;
		logic rm_prev;
	} apply_t;

endpackage
`default_nettype wire

FILE: hw/rtl/kmpq_cell.sv
// One slot of the sorted entry chain: compare against a command, then shift or load.
`default_nettype none
module kmpq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  kmpq_pkg::cmp_t   cmp,
	input  kmpq_pkg::apply_t ctl,
	input  kmpq_pkg::ent_t   ins_ent,
	input  kmpq_pkg::nb_t    prev,
	input  kmpq_pkg::nb_t    next,
	output kmpq_pkg::nb_t    self,
	output logic            match
);
	import kmpq_pkg::*;

	logic valid_q;
	key_t key_q;
	val_t value_q;
	logic lt_q;
	logic le_q;
	nb_t  own;
	nb_t  rsel;
	nb_t  rprev;
	logic l_r;
	logic l_p;
	ent_t nxt;

	always_comb begin
		own.ent.valid = valid_q;
		own.ent.key   = key_q;
		own.ent.value = value_q;
		own.lt        = lt_q;
		own.le        = le_q;
		rsel  = ctl.rm_here ? next : own;
		rprev = ctl.rm_prev ? own : prev;
		l_r   = ctl.sel_lt ? rsel.lt : rsel.le;
		l_p   = ctl.sel_lt ? rprev.lt : rprev.le;
		priority if (!ctl.ins || l_r) begin
			nxt = rsel.ent;
		end else if (l_p) begin
			nxt = ins_ent;
		end else begin
			nxt = rprev.ent;
		end
	end

	assign self  = own;
	assign match = valid_q && (key_q == cmp.key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			le_q    <= 1'b0;
		end else begin
			if (cmp.load) begin
				lt_q <= valid_q && (value_q < cmp.value);
				le_q <= valid_q && (value_q <= cmp.value);
			end
			if (ctl.apply) begin
				valid_q <= nxt.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.apply) begin
			key_q   <= nxt.key;
			value_q <= nxt.value;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/keyed_min_priority_queue.sv
// Top level of the keyed minimum priority queue built on a chain of sorted cells.
// Usage:
//   Raise start with a command on cmd (mode, in_key, in_value); the transaction is taken
//   at a rising edge with start high and busy low. Mode 0 adds or updates a key, mode 1
//   only updates, mode 2 removes the smallest entry.
//   In the accept cycle every cell compares its entry with the command and records
//   key match and order flags. The next cycle (busy high) every cell picks its new
//   entry from itself, a neighbor or the command, so the whole row shifts at once.
//   Exactly one result follows each command: res_valid pulses for one cycle, registered
//   from the execution state, with res carrying the dequeued entry (or zeros), status,
//   queue_empty and fill_level after the step. A command passes through the compare step
//   and then the shift step of the cell chain; no new command is taken while busy.
//   start may be held high to issue back-to-back commands; the next one is taken in the
//   same cycle that the previous result is shown.
//   The receiver cannot stall: a result not taken in its cycle is gone.
//   Reset: arst_n clears all entry valid bits and the fill count; the queue is
//   empty and ready right after reset.
`default_nettype none
module keyed_min_priority_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  kmpq_pkg::in_t  cmd,
	output logic           busy,
	output logic           res_valid,
	output kmpq_pkg::out_t res
);
	import kmpq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic             state_q;
	logic [1:0]       mode_q;
	key_t             key_q;
	val_t             value_q;
	logic             found_q;
	logic [IDX_W-1:0] mpos_q;
	logic [CNT_W-1:0] count_q;
	out_t             res_q;
	logic             res_valid_q;

	logic             accept;
	logic             exec;
	cmp_t             cmp;
	ent_t             ins_ent;
	logic [DEPTH-1:0] match;
	nb_t              nb [DEPTH];
	apply_t           ctl [DEPTH];
	logic             found_c;
	logic [IDX_W-1:0] mpos_c;
	logic             rm;
	logic             ins;
	logic             sel_lt;
	logic [IDX_W-1:0] m_rm;
	logic [1:0]       status_c;
	logic [CNT_W-1:0] count_n;
	out_t             res_c;

	assign busy   = (state_q == ST_EXEC);
	assign accept = start && !busy;
	assign exec   = (state_q == ST_EXEC);

	always_comb begin
		cmp.load  = accept;
		cmp.key   = cmd.in_key[KEY_BITS-1:0];
		cmp.value = cmd.in_value;
		ins_ent.valid = 1'b1;
		ins_ent.key   = key_q;
		ins_ent.value = value_q;
	end

	always_comb begin
		found_c = |match;
		mpos_c  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				mpos_c = mpos_c | IDX_W'(i);
			end
		end
	end

	always_comb begin
		rm       = 1'b0;
		ins      = 1'b0;
		sel_lt   = 1'b0;
		m_rm     = mpos_q;
		status_c = STAT_DONE;
		count_n  = count_q;
		res_c    = '0;
		unique case (mode_q)
			MODE_ADD, MODE_UPD: begin
				if (found_q) begin
					rm     = 1'b1;
					ins    = 1'b1;
					sel_lt = 1'b1;
				end else if (mode_q == MODE_UPD) begin
					status_c = STAT_ABSENT;
				end else if (count_q == CNT_W'(DEPTH)) begin
					status_c = STAT_FULL;
				end else begin
					ins     = 1'b1;
					count_n = count_q + 1'b1;
				end
			end
			MODE_DEQ: begin
				if (count_q == '0) begin
					status_c = STAT_EMPTY;
				end else begin
					rm              = 1'b1;
					m_rm            = '0;
					count_n         = count_q - 1'b1;
					res_c.out_key   = IN_KEY_W'(nb[0].ent.key);
					res_c.out_value = nb[0].ent.value;
					res_c.out_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_c.status      = status_c;
		res_c.queue_empty = (count_n == '0);
		res_c.fill_level  = FILL_W'(count_n);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		nb_t prev_nb;
		nb_t next_nb;

		always_comb begin
			ctl[i].apply   = exec;
			ctl[i].ins     = ins;
			ctl[i].sel_lt  = sel_lt;
			ctl[i].rm_here = rm && (IDX_W'(i) >= m_rm);
			ctl[i].rm_prev = rm && (IDX_W'(i) > m_rm);
		end

		if (i == 0) begin : g_head
			assign prev_nb = '{ent: '0, lt: 1'b1, le: 1'b1};
		end else begin : g_body
			assign prev_nb = nb[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_nb = '0;
		end else begin : g_mid
			assign next_nb = nb[i+1];
		end

		kmpq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmp     (cmp),
			.ctl     (ctl[i]),
			.ins_ent (ins_ent),
			.prev    (prev_nb),
			.next    (next_nb),
			.self    (nb[i]),
			.match   (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= exec;
			if (exec) begin
				count_q <= count_n;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= cmd.mode;
			key_q   <= cmd.in_key[KEY_BITS-1:0];
			value_q <= cmd.in_value;
			found_q <= found_c;
			mpos_q  <= mpos_c;
		end
		if (exec) begin
			res_q <= res_c;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

FILE: hw/rtl/kmpq_checker.sv
// Port-level checks for the keyed minimum priority queue and their bind.
`default_nettype none
module kmpq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           res_valid,
	input kmpq_pkg::out_t res
);
	import kmpq_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !res_valid)
		else $error("accepted transaction did not enter execution");

	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> res_valid && !busy)
		else $error("execution cycle did not produce exactly one result");

	a_deq_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.out_valid |-> res.status == STAT_DONE)
		else $error("dequeued entry reported with error status");

	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.queue_empty == (res.fill_level == '0))
			&& (res.fill_level <= FILL_W'(DEPTH)))
		else $error("empty flag or fill level inconsistent");

endmodule

bind keyed_min_priority_queue kmpq_checker u_kmpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res)
);
`default_nettype wire
